@@ hw/rtl/rcaa_pkg.sv @@
// Shared types and constants of the ring command area allocator.
package rcaa_pkg;

    localparam int AREA_BYTES = 16384;

    localparam int PAYLOAD_W = 15;
    localparam int CODE_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int OFFSET_W  = $clog2(AREA_BYTES);
    localparam int CNT_W     = 13;

    localparam logic MODE_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_SIZE  = 2'd1,
        STAT_NO_SPACE  = 2'd2,
        STAT_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_READ_LAST,
        S_EVAL,
        S_LINK,
        S_STORE,
        S_DONE
    } t_state;

endpackage

@@ hw/rtl/rcaa_ram.sv @@
// Single-port-write, single-port-read synchronous memory with registered read data.
module rcaa_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 14
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/rcaa_fit.sv @@
// Sanity checks of the oldest and newest commands and placement of a new command.
module rcaa_fit #(
    parameter int AREA_BYTES           = 16384,
    parameter int HEADER_BYTES         = 28,
    parameter int COMMAND_HEADER_BYTES = 12,
    parameter int OFF_W                = 14,
    parameter int SIZE_W               = 15,
    parameter int CW                   = 17
) (
    input  logic [OFF_W-1:0]  i_first,
    input  logic [OFF_W-1:0]  i_last,
    input  logic [SIZE_W-1:0] i_first_sz,
    input  logic [SIZE_W-1:0] i_last_sz,
    input  logic [CW-1:0]     i_size,
    output logic              o_placed,
    output logic [OFF_W-1:0]  o_off
);
    localparam logic [CW-1:0] AREA  = CW'(AREA_BYTES);
    localparam logic [CW-1:0] START = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] CHB   = CW'(COMMAND_HEADER_BYTES);

    function automatic logic [CW-1:0] align4(input logic [CW-1:0] v);
        return (v + CW'(3)) & ~CW'(3);
    endfunction

    function automatic logic cmd_ok(input logic [CW-1:0] off, input logic [CW-1:0] sz);
        logic ok;
        ok = 1'b1;
        if (off < START || off + CHB > AREA || off[1:0] != 2'b00) begin
            ok = 1'b0;
        end
        if (sz < CHB || off + align4(sz) > AREA) begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    logic [CW-1:0] first_w;
    logic [CW-1:0] last_w;
    logic [CW-1:0] first_sz_w;
    logic [CW-1:0] last_sz_w;
    logic [CW-1:0] end_w;
    logic          both_ok;

    always_comb begin
        first_w    = CW'(i_first);
        last_w     = CW'(i_last);
        first_sz_w = CW'(i_first_sz);
        last_sz_w  = CW'(i_last_sz);
        end_w      = last_w + align4(last_sz_w);
        both_ok    = cmd_ok(first_w, first_sz_w) && cmd_ok(last_w, last_sz_w);
        o_placed   = 1'b0;
        o_off      = '0;
        if (both_ok) begin
            if (first_w <= last_w) begin
                if (i_size <= AREA - end_w) begin
                    o_placed = 1'b1;
                    o_off    = OFF_W'(end_w);
                end else if (i_size <= first_w - START) begin
                    o_placed = 1'b1;
                    o_off    = OFF_W'(START);
                end
            end else if (end_w <= first_w && i_size <= first_w - end_w) begin
                o_placed = 1'b1;
                o_off    = OFF_W'(end_w);
            end
        end
    end

endmodule

@@ hw/rtl/ring_command_area_allocator.sv @@
// Top level of the ring command area allocator: sequencer, ring registers and stores.
//
//   Channel  Direction  Handshake                 Fields
//   in       input      i_in_valid / o_in_stall   i_mode, i_payload_size, i_command_code
//   out      output     o_out_valid / i_out_stall o_status, o_offset, o_was_empty
//
// An allocate behind existing commands reads both end commands' sizes in turn from the
// single-read size store and then makes two link writes; one that finds no space stops after
// the reads. A release, a bad size and an allocate into an empty ring read no sizes.
// Reset empties the ring at once; the stores need no clearing.
// A new transaction is taken while the previous result still waits in the output register;
// the next result then waits in its last cycle until that register is free.
module ring_command_area_allocator #(
    parameter int HEADER_BYTES         = 28,
    parameter int COMMAND_HEADER_BYTES = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_mode,
    input  logic [rcaa_pkg::PAYLOAD_W-1:0] i_payload_size,
    input  logic [rcaa_pkg::CODE_W-1:0]    i_command_code,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [rcaa_pkg::STATUS_W-1:0]  o_status,
    output logic [rcaa_pkg::OFFSET_W-1:0]  o_offset,
    output logic                           o_was_empty
);
    import rcaa_pkg::*;

    localparam int OFF_W  = $clog2(AREA_BYTES);
    localparam int SIZE_W = OFF_W + 1;
    localparam int DEPTH  = AREA_BYTES / 4;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CW     = (OFF_W + 2 > PAYLOAD_W + 2) ? OFF_W + 2 : PAYLOAD_W + 2;
    localparam logic [OFF_W-1:0] START    = OFF_W'(HEADER_BYTES);
    localparam logic [CW-1:0]    MAX_SIZE = CW'(AREA_BYTES - HEADER_BYTES);

    function automatic logic [IDX_W-1:0] word_index(input logic [OFF_W-1:0] off);
        logic [OFF_W-1:0] w;
        w = off >> 2;
        return (w < OFF_W'(DEPTH)) ? IDX_W'(w) : '0;
    endfunction

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [OFF_W-1:0]    r_first, n_first;
    logic [OFF_W-1:0]    r_last, n_last;
    logic [OFF_W-1:0]    r_prev_last, n_prev_last;
    logic [OFF_W-1:0]    r_off, n_off;
    logic [CW-1:0]       r_size, n_size;
    logic [CODE_W-1:0]   r_code, n_code;
    logic [SIZE_W-1:0]   r_first_sz, n_first_sz;
    t_status             r_status, n_status;
    logic                r_empty, n_empty;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [OFFSET_W-1:0] r_out_off, n_out_off;
    logic                r_out_empty, n_out_empty;

    logic              accept;
    logic              out_free;
    logic [CW-1:0]     in_size;
    logic              bad_size;
    logic [IDX_W-1:0]  rd_idx;
    logic              link_we;
    logic [IDX_W-1:0]  link_waddr;
    logic [OFF_W-1:0]  link_wdata;
    logic [OFF_W-1:0]  link_rdata;
    logic              store_we;
    logic [IDX_W-1:0]  store_waddr;
    logic [SIZE_W-1:0] size_rdata;
    logic              fit_placed;
    logic [OFF_W-1:0]  fit_off;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign in_size  = CW'(COMMAND_HEADER_BYTES) + CW'(i_payload_size);
    assign bad_size = in_size > MAX_SIZE;

    rcaa_ram #(.DEPTH(DEPTH), .WIDTH(OFF_W)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (rd_idx),
        .o_rdata (link_rdata)
    );

    rcaa_ram #(.DEPTH(DEPTH), .WIDTH(SIZE_W)) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (SIZE_W'(r_size)),
        .i_raddr (rd_idx),
        .o_rdata (size_rdata)
    );

    rcaa_ram #(.DEPTH(DEPTH), .WIDTH(CODE_W)) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (r_code),
        .i_raddr (rd_idx),
        .o_rdata ()
    );

    rcaa_fit #(
        .AREA_BYTES           (AREA_BYTES),
        .HEADER_BYTES         (HEADER_BYTES),
        .COMMAND_HEADER_BYTES (COMMAND_HEADER_BYTES),
        .OFF_W                (OFF_W),
        .SIZE_W               (SIZE_W),
        .CW                   (CW)
    ) u_fit (
        .i_first    (r_first),
        .i_last     (r_last),
        .i_first_sz (r_first_sz),
        .i_last_sz  (size_rdata),
        .i_size     (r_size),
        .o_placed   (fit_placed),
        .o_off      (fit_off)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_mode == MODE_RELEASE) begin
                        n_state = (r_count == '0) ? S_DONE : S_POP;
                    end else if (bad_size) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = (r_count == '0) ? S_STORE : S_READ_LAST;
                    end
                end
            end
            S_POP:       n_state = S_DONE;
            S_READ_LAST: n_state = S_EVAL;
            S_EVAL:      n_state = fit_placed ? S_LINK : S_DONE;
            S_LINK:      n_state = S_STORE;
            S_STORE:     n_state = S_DONE;
            S_DONE:      n_state = out_free ? S_IDLE : S_DONE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        rd_idx      = (r_state == S_READ_LAST) ? word_index(r_last) : word_index(r_first);
        link_we     = (r_state == S_LINK) || (r_state == S_STORE);
        link_waddr  = (r_state == S_LINK) ? word_index(r_prev_last) : word_index(r_off);
        link_wdata  = (r_state == S_LINK) ? r_off : '0;
        store_we    = (r_state == S_STORE);
        store_waddr = word_index(r_off);
    end

    always_comb begin
        n_count      = r_count;
        n_first      = r_first;
        n_last       = r_last;
        n_prev_last  = r_prev_last;
        n_off        = r_off;
        n_size       = r_size;
        n_code       = r_code;
        n_first_sz   = r_first_sz;
        n_status     = r_status;
        n_empty      = r_empty;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_off    = r_out_off;
        n_out_empty  = r_out_empty;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_size   = in_size;
                    n_code   = i_command_code;
                    n_status = STAT_OK;
                    n_off    = '0;
                    n_empty  = 1'b0;
                    if (i_mode == MODE_RELEASE) begin
                        if (r_count == '0) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            n_off = r_first;
                        end
                    end else if (bad_size) begin
                        n_status = STAT_BAD_SIZE;
                    end else if (r_count == '0) begin
                        n_off   = START;
                        n_empty = 1'b1;
                        n_count = CNT_W'(1);
                        n_first = START;
                        n_last  = START;
                    end
                end
            end
            S_POP: begin
                n_count = r_count - CNT_W'(1);
                if (r_count == CNT_W'(1)) begin
                    n_first = '0;
                    n_last  = '0;
                end else begin
                    n_first = link_rdata;
                end
            end
            S_READ_LAST: begin
                n_first_sz = size_rdata;
            end
            S_EVAL: begin
                if (fit_placed) begin
                    n_off       = fit_off;
                    n_count     = r_count + CNT_W'(1);
                    n_prev_last = r_last;
                    n_last      = fit_off;
                end else begin
                    n_status = STAT_NO_SPACE;
                    n_off    = '0;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_off    = OFFSET_W'(r_off);
                    n_out_empty  = r_empty;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_first     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_first     <= n_first;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev_last  <= n_prev_last;
        r_off        <= n_off;
        r_size       <= n_size;
        r_code       <= n_code;
        r_first_sz   <= n_first_sz;
        r_status     <= n_status;
        r_empty      <= n_empty;
        r_out_status <= n_out_status;
        r_out_off    <= n_out_off;
        r_out_empty  <= n_out_empty;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_offset    = r_out_off;
    assign o_was_empty = r_out_empty;

endmodule

@@ hw/rtl/rcaa_checker.sv @@
// Port-level checks of the ring command area allocator and their binding to the top level.
module rcaa_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [rcaa_pkg::STATUS_W-1:0]  o_status,
    input logic [rcaa_pkg::OFFSET_W-1:0]  o_offset,
    input logic                           o_was_empty
);
    import rcaa_pkg::*;

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid after reset.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("Block took a transaction without going busy.");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_status) && $stable(o_offset) && $stable(o_was_empty)))
        else $error("Stalled result changed.");

    a_failure_has_no_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != STAT_OK) |-> (o_offset == '0 && !o_was_empty))
        else $error("Failed transaction reports an offset or an empty ring.");

endmodule

bind ring_command_area_allocator rcaa_checker u_rcaa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status),
    .o_offset    (o_offset),
    .o_was_empty (o_was_empty)
);
